FILE: hdl/psh_pkg.sv
// Package for the polynomial string hash block: field widths, hash and bucket
// constants, and the two constant fold tables used for modular reduction.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package psh_pkg;

  localparam int CHAR_W  = 8;
  localparam int HASH_W  = 31;
  localparam int POW_W   = 30;
  localparam int PROD_W  = CHAR_W + POW_W;
  localparam int REM_W   = 31;
  localparam int LIMIT_W = 16;
  localparam int FOLD_IDX_W = 8;
  localparam int POW_X_W = POW_W + 5;

  localparam longint HASH_MOD  = 64'd1000000007;
  localparam longint HASH_BASE = 64'd31;

  localparam logic [POW_W-1:0]        MOD_P         = 30'd1000000007;
  localparam logic [REM_W-1:0]        MOD_P_X2      = 31'd2000000014;
  localparam logic signed [CHAR_W:0]  CHAR_OFFSET   = 9'sd96;
  localparam logic signed [HASH_W-1:0] IDX_XOR_IN   = 31'sd7;
  localparam logic [6:0]              IDX_XOR_OUT   = 7'd11;
  localparam logic [7:0]              IDX_ADD       = 8'd7;
  localparam logic [30:0]             DIV34_RECIP   = 31'd2021161081;
  localparam int                      DIV34_SHIFT   = 36;
  localparam logic [LIMIT_W-1:0]      LIMIT_RESET   = 16'd64;
  localparam logic [LIMIT_W-1:0]      BUCKET_ONES   = 16'hFFFF;

  typedef logic [POW_X_W-1:0] pow_fold_t;
  typedef pow_fold_t pow_fold_tbl_t [2**FOLD_IDX_W];
  typedef logic [PROD_W-1:0] prod_fold_t;
  typedef prod_fold_t prod_fold_tbl_t [2**FOLD_IDX_W];

  // Entry i is the largest multiple of the modulus not above 31 * i * 2^22,
  // indexed by the top byte of the power.
  function automatic pow_fold_tbl_t make_pow_fold();
    pow_fold_tbl_t tbl;
    longint unsigned quo;
    for (int i = 0; i < 2**FOLD_IDX_W; i++) begin
      quo = (HASH_BASE * longint'(i) * (64'd1 << (POW_W - FOLD_IDX_W))) / HASH_MOD;
      tbl[i] = POW_X_W'(quo * HASH_MOD);
    end
    return tbl;
  endfunction

  // Entry i is the largest multiple of the modulus not above i * 2^30,
  // indexed by the top byte of the product.
  function automatic prod_fold_tbl_t make_prod_fold();
    prod_fold_tbl_t tbl;
    longint unsigned quo;
    for (int i = 0; i < 2**FOLD_IDX_W; i++) begin
      quo = (longint'(i) * (64'd1 << (PROD_W - FOLD_IDX_W))) / HASH_MOD;
      tbl[i] = PROD_W'(quo * HASH_MOD);
    end
    return tbl;
  endfunction

  localparam pow_fold_tbl_t  POW_FOLD  = make_pow_fold();
  localparam prod_fold_tbl_t PROD_FOLD = make_prod_fold();

endpackage

`default_nettype wire

FILE: hdl/psh_if.sv
// Channel interfaces of the polynomial string hash block: character input,
// result output and the bucket limit write channel. Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface psh_in_if import psh_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface psh_out_if import psh_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [HASH_W-1:0] key_hash;
  logic [LIMIT_W-1:0]       bucket_index;

  modport source (output valid, output key_hash, output bucket_index, input ready);
  modport sink   (input valid, input key_hash, input bucket_index, output ready);
endinterface

interface psh_cfg_if import psh_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] bucket_limit;

  modport source (output valid, output bucket_limit, input ready);
  modport sink   (input valid, input bucket_limit, output ready);
endinterface

`default_nettype wire

FILE: hdl/psh_hash_pipe.sv
// Hash pipeline: running power, product of character weight and power, its
// reduction modulo 1000000007, and the signed running hash update.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psh_hash_pipe import psh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CHAR_W-1:0]        char_code,
  input  logic                     is_last,
  output logic                     hash_valid,
  input  logic                     hash_ready,
  output logic signed [HASH_W-1:0] key_hash
);

  localparam logic signed [32:0] M33 = 33'sd1000000007;

  logic [POW_W-1:0]   power;
  logic [POW_W-1:0]   power_next;
  logic [POW_X_W-1:0] pow_x31;
  logic [POW_X_W-1:0] pow_r0;
  logic [POW_X_W-1:0] pow_r1;

  logic signed [CHAR_W:0] char_d;
  logic [CHAR_W:0]        char_neg;
  logic [CHAR_W-1:0]      char_mag;

  logic                s1_valid, s1_last, s1_neg;
  logic [CHAR_W-1:0]   s1_mag;
  logic [POW_W-1:0]    s1_pow;
  logic                s2_valid, s2_last, s2_neg;
  logic [PROD_W-1:0]   s2_prod;
  logic                s3_valid, s3_last, s3_neg, s3_big;
  logic [REM_W-1:0]    s3_rem;
  logic                s4_valid, s4_last, s4_neg, s4_big;
  logic [POW_W-1:0]    s4_rm;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic fire4;

  logic signed [HASH_W-1:0] running_hash;
  logic signed [32:0]       acc_t;
  logic signed [32:0]       acc_sel;
  logic                     ge_m, ge_z, ge_nm, res_neg, zero_r;
  logic signed [HASH_W-1:0] hash_new;

  always_comb begin
    pow_x31    = {power, 5'b0} - {5'b0, power};
    pow_r0     = pow_x31 - POW_FOLD[power[POW_W-1 -: FOLD_IDX_W]];
    pow_r1     = pow_r0 - {5'b0, MOD_P};
    power_next = (pow_r0 >= {5'b0, MOD_P}) ? pow_r1[POW_W-1:0] : pow_r0[POW_W-1:0];
  end

  always_comb begin
    char_d   = $signed({char_code[CHAR_W-1], char_code}) - CHAR_OFFSET;
    char_neg = -char_d;
    char_mag = char_d[CHAR_W] ? char_neg[CHAR_W-1:0] : char_d[CHAR_W-1:0];
  end

  assign rdy5     = !hash_valid || hash_ready;
  assign rdy4     = !s4_valid || !s4_last || rdy5;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;
  assign fire4    = s4_valid && (!s4_last || rdy5);

  always_comb begin
    acc_t = s4_neg ? ({{2{running_hash[HASH_W-1]}}, running_hash} - {3'b0, s4_rm})
                   : ({{2{running_hash[HASH_W-1]}}, running_hash} + {3'b0, s4_rm});
    ge_m    = acc_t >= M33;
    ge_z    = !acc_t[32];
    ge_nm   = acc_t >= -M33;
    zero_r  = (acc_t == M33) || (acc_t == 33'sd0) || (acc_t == -M33);
    res_neg = s4_big ? s4_neg : acc_t[32];
    if (!res_neg || zero_r) begin
      if (ge_m) begin
        acc_sel = acc_t - M33;
      end else if (ge_z) begin
        acc_sel = acc_t;
      end else if (ge_nm) begin
        acc_sel = acc_t + M33;
      end else begin
        acc_sel = acc_t + M33 + M33;
      end
    end else begin
      if (ge_m) begin
        acc_sel = acc_t - M33 - M33;
      end else if (ge_z) begin
        acc_sel = acc_t - M33;
      end else if (ge_nm) begin
        acc_sel = acc_t;
      end else begin
        acc_sel = acc_t + M33;
      end
    end
    hash_new = acc_sel[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power        <= POW_W'(1);
      running_hash <= '0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      hash_valid   <= 1'b0;
    end else begin
      if (in_valid && rdy1) begin
        power <= is_last ? POW_W'(1) : power_next;
      end
      if (fire4) begin
        running_hash <= s4_last ? '0 : hash_new;
      end
      if (rdy1) s1_valid <= in_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy4) s4_valid <= s3_valid;
      if (rdy5) hash_valid <= s4_valid && s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_mag  <= char_mag;
      s1_neg  <= char_d[CHAR_W];
      s1_pow  <= power;
      s1_last <= is_last;
    end
    if (s1_valid && rdy2) begin
      s2_prod <= PROD_W'(s1_mag) * PROD_W'(s1_pow);
      s2_neg  <= s1_neg;
      s2_last <= s1_last;
    end
    if (s2_valid && rdy3) begin
      s3_rem  <= REM_W'(s2_prod - PROD_FOLD[s2_prod[PROD_W-1 -: FOLD_IDX_W]]);
      s3_big  <= s2_prod >= PROD_W'(MOD_P);
      s3_neg  <= s2_neg;
      s3_last <= s2_last;
    end
    if (s3_valid && rdy4) begin
      if (s3_rem >= MOD_P_X2) begin
        s4_rm <= POW_W'(s3_rem - MOD_P_X2);
      end else if (s3_rem >= {1'b0, MOD_P}) begin
        s4_rm <= POW_W'(s3_rem - {1'b0, MOD_P});
      end else begin
        s4_rm <= s3_rem[POW_W-1:0];
      end
      s4_big  <= s3_big;
      s4_neg  <= s3_neg;
      s4_last <= s3_last;
    end
    if (s4_valid && s4_last && rdy5) begin
      key_hash <= hash_new;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/psh_bucket.sv
// Bucket index pipeline: truncating remainder by 34 through a reciprocal
// multiply, the xor and offset steps, and the shift down to the bucket limit.
// Depends on psh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psh_bucket import psh_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     hash_valid,
  output logic                     hash_ready,
  input  logic signed [HASH_W-1:0] key_hash,
  input  logic [LIMIT_W-1:0]       limit,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [HASH_W-1:0] out_hash,
  output logic [LIMIT_W-1:0]       out_bucket
);

  logic signed [HASH_W-1:0] hash_x;
  logic [HASH_W-1:0]        hash_xn;
  logic [POW_W-1:0]         hash_mag;

  logic                     a_valid, a_neg;
  logic [POW_W-1:0]         a_mag;
  logic signed [HASH_W-1:0] a_hash;
  logic [60:0]              div_prod;

  logic                     b_valid, b_neg;
  logic [5:0]               b_q6, b_a6;
  logic signed [HASH_W-1:0] b_hash;

  logic [5:0]         q34;
  logic [5:0]         rem6;
  logic [6:0]         rem_s;
  logic [6:0]         rem_x;
  logic [7:0]         idx_s;
  logic [LIMIT_W-1:0] cand;
  logic [LIMIT_W-1:0] bucket_sel;

  logic rdy_a, rdy_b, rdy_o;

  assign rdy_o      = !out_valid || out_ready;
  assign rdy_b      = !b_valid || rdy_o;
  assign rdy_a      = !a_valid || rdy_b;
  assign hash_ready = rdy_a;

  always_comb begin
    hash_x   = key_hash ^ IDX_XOR_IN;
    hash_xn  = -hash_x;
    hash_mag = hash_x[HASH_W-1] ? hash_xn[POW_W-1:0] : hash_x[POW_W-1:0];
  end

  assign div_prod = 61'(a_mag) * 61'(DIV34_RECIP);

  // The remainder is below 64, so the low six bits of the quotient suffice.
  always_comb begin
    q34   = 6'({b_q6, 5'b0}) + 6'({b_q6, 1'b0});
    rem6  = b_a6 - q34;
    rem_s = b_neg ? -{1'b0, rem6} : {1'b0, rem6};
    rem_x = rem_s ^ IDX_XOR_OUT;
    idx_s = {rem_x[6], rem_x} + IDX_ADD;
  end

  // A negative index wraps to a 64-bit value whose shifted forms fit 16 bits
  // only once they are all ones, so only those shapes are tried.
  always_comb begin
    bucket_sel = '0;
    cand       = '0;
    if (idx_s[7]) begin
      for (int j = 7; j >= 0; j--) begin
        cand = BUCKET_ONES >> (2 * j);
        if (cand <= limit) bucket_sel = cand;
      end
    end else begin
      for (int j = 3; j >= 0; j--) begin
        cand = LIMIT_W'(idx_s[6:0]) >> (2 * j);
        if (cand <= limit) bucket_sel = cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) a_valid <= hash_valid;
      if (rdy_b) b_valid <= a_valid;
      if (rdy_o) out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hash_valid && rdy_a) begin
      a_mag  <= hash_mag;
      a_neg  <= hash_x[HASH_W-1];
      a_hash <= key_hash;
    end
    if (a_valid && rdy_b) begin
      b_q6   <= div_prod[DIV34_SHIFT +: 6];
      b_a6   <= a_mag[5:0];
      b_neg  <= a_neg;
      b_hash <= a_hash;
    end
    if (b_valid && rdy_o) begin
      out_hash   <= b_hash;
      out_bucket <= bucket_sel;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/poly_string_hash_bucket_index.sv
// Top level of the polynomial string hash block with bucket index.
// Depends on psh_pkg, the channel interfaces, psh_hash_pipe and psh_bucket.
//
// Usage: a key arrives on the chars channel one character per transaction,
// with is_last set on its final character. The characters of a key, and
// of the keys that follow, may come one per cycle while chars.ready is high.
// For each key one transaction leaves on the result channel, carrying the
// signed hash modulo 1000000007 and the bucket index, which is shifted down
// by two bits at a time until it does not exceed bucket_limit.
// From the transaction of the last character to a valid result, five
// pipeline registers form the hash, two more form the remainder by 34,
// and the output register holds the result. Throughput is one character
// per cycle while chars.ready is high; the running hash update is a
// single add followed by a select among five correction candidates.
// The cfg channel is always ready and writes bucket_limit; it should be
// written only while no key is in flight. Reset sets bucket_limit to 64,
// clears the running hash to zero, the running power to one, and empties
// the pipeline. When the receiver stalls, the output register holds its
// result and the pipeline keeps accepting characters until its registers
// fill, after which chars.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module poly_string_hash_bucket_index import psh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  psh_in_if.sink    chars,
  psh_out_if.source result,
  psh_cfg_if.sink   cfg
);

  logic [LIMIT_W-1:0]       bucket_limit;
  logic                     hash_valid;
  logic                     hash_ready;
  logic signed [HASH_W-1:0] key_hash;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      bucket_limit <= cfg.bucket_limit;
    end
  end

  psh_hash_pipe u_hash (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chars.valid),
    .in_ready   (chars.ready),
    .char_code  (chars.char_code),
    .is_last    (chars.is_last),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .key_hash   (key_hash)
  );

  psh_bucket u_bucket (
    .clk        (clk),
    .rst        (rst),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .key_hash   (key_hash),
    .limit      (bucket_limit),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_hash   (result.key_hash),
    .out_bucket (result.bucket_index)
  );

endmodule

`default_nettype wire
